// ===== rtl/core/fpprot_pkg.sv =====
package fpprot_pkg;

  localparam int unsigned MaxDimension = 8192;
  localparam int unsigned DimW = 14;
  localparam int unsigned CntW = 13;
  localparam int unsigned IdxW = 28;
  localparam int unsigned ChanW = 16;
  localparam logic [ChanW-1:0] ChannelMax = 16'hFFFF;

  localparam logic [2:0] CfgRotation = 3'd0;
  localparam logic [2:0] CfgFormat = 3'd1;
  localparam logic [2:0] CfgRegionW = 3'd2;
  localparam logic [2:0] CfgRegionH = 3'd3;
  localparam logic [2:0] CfgTargetW = 3'd4;
  localparam logic [2:0] CfgTargetH = 3'd5;
  localparam logic [2:0] CfgOffsetX = 3'd6;
  localparam logic [2:0] CfgOffsetY = 3'd7;

  localparam logic [2:0] FmtRgba8 = 3'd0;
  localparam logic [2:0] FmtBgra8 = 3'd1;
  localparam logic [2:0] FmtRgba16 = 3'd2;
  localparam logic [2:0] FmtRgb16 = 3'd3;
  localparam logic [2:0] FmtRgb8 = 3'd4;

  localparam logic [1:0] Rot0 = 2'd0;
  localparam logic [1:0] Rot90 = 2'd1;
  localparam logic [1:0] Rot180 = 2'd2;
  localparam logic [1:0] Rot270 = 2'd3;

  typedef struct packed {
    logic [1:0]      rotation;
    logic [2:0]      format;
    logic [DimW-1:0] region_w;
    logic [DimW-1:0] region_h;
    logic [DimW-1:0] target_w;
    logic [DimW-1:0] target_h;
    logic [CntW-1:0] offset_x;
    logic [CntW-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] col;
    logic [CntW-1:0] row;
    logic            last;
  } pos_t;

  // Clamp a region size into 1..MaxDimension.
  function automatic logic [DimW-1:0] eff_size(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxDimension)) r = DimW'(MaxDimension);
    return r;
  endfunction

endpackage

// ===== rtl/core/fpprot_conv.sv =====
module fpprot_conv (
  input  logic [31:0] bits_in,
  input  logic        wide,
  output logic [15:0] value
);
  import fpprot_pkg::*;

  // f*65535 rounded to single, truncated. Product = m*(2^16-1), m 24 bits.
  logic [7:0]  expo;
  logic [23:0] mant;
  logic [39:0] prod;
  logic [5:0]  msb;
  logic [39:0] rnd;
  logic [40:0] rsum;
  logic [40:0] keep;
  logic        lsb, half, sticky, up;
  logic [5:0]  cut;
  logic [39:0] lowmask;
  logic [8:0]  sh;
  logic [80:0] scaled;
  logic [15:0] conv;

  always_comb begin
    expo = bits_in[30:23];
    mant = {1'b1, bits_in[22:0]};
    prod = {mant, 16'h0} - {16'h0, mant};
    msb = 6'd0;
    for (int i = 0; i < 40; i++) begin
      if (prod[i]) msb = 6'(i);
    end
    cut = (msb > 6'd23) ? msb - 6'd23 : 6'd0;
    lowmask = (40'd1 << cut) - 40'd1;
    lsb = (cut == 6'd0) ? 1'b0 : prod[cut];
    half = (cut == 6'd0) ? 1'b0 : prod[cut - 6'd1];
    sticky = (cut <= 6'd1) ? 1'b0 : |(prod & (lowmask >> 1));
    up = half && (sticky || lsb);
    rnd = prod & ~lowmask;
    rsum = {1'b0, rnd} + (up ? (41'd1 << cut) : 41'd0);
    keep = rsum;
    // value = rsum * 2^(expo-127-23); shift right by 150-expo
    sh = 9'd150 - {1'b0, expo};
    scaled = {keep, 40'h0} >> sh;
    if (bits_in[31] || expo == 8'd0) conv = '0;
    else if (expo == 8'hFF) conv = (bits_in[22:0] != '0) ? '0 : ChannelMax;
    else if (expo > 8'd142) conv = ChannelMax;
    else if (expo < 8'd100) conv = '0;
    else if (scaled[80:56] != '0) conv = ChannelMax;
    else conv = scaled[55:40];
    value = wide ? conv : {8'h00, conv[15:8]};
  end

endmodule

// ===== rtl/core/fpprot_place.sv =====
module fpprot_place (
  input  fpprot_pkg::cfg_t          cfg,
  input  fpprot_pkg::pos_t          pos,
  input  logic [2:0]                step,
  output logic [fpprot_pkg::IdxW-1:0] index,
  output logic                      outside
);
  import fpprot_pkg::*;

  logic signed [16:0] x, y, px, py, tw, th, ox, oy;
  logic [27:0] base;
  logic [29:0] full;

  always_comb begin
    x = 17'($unsigned(pos.col));
    y = 17'($unsigned(pos.row));
    px = 17'($unsigned(cfg.offset_x));
    py = 17'($unsigned(cfg.offset_y));
    tw = 17'($unsigned(cfg.target_w));
    th = 17'($unsigned(cfg.target_h));
    unique case (cfg.rotation)
      Rot90: begin
        oy = x + py;
        ox = tw - (y + px) - 17'sd1;
      end
      Rot180: begin
        oy = th - (y + py) - 17'sd1;
        ox = tw - (x + px) - 17'sd1;
      end
      Rot270: begin
        oy = th - (x + py) - 17'sd1;
        ox = y + px;
      end
      default: begin
        oy = y + py;
        ox = x + px;
      end
    endcase
    outside = ox < 0 || ox >= tw || oy < 0 || oy >= th;
    base = 28'({14'd0, oy[13:0]} * {14'd0, cfg.target_w}) + 28'(ox[13:0]);
    full = {2'b0, base} * 30'(step);
    index = outside ? '0 : full[IdxW-1:0];
  end

endmodule

// ===== rtl/core/float_pixel_pack_rotate_top.sv =====
// Float RGBA pixel packer with rotated, tiled placement.
// Input channel: in_valid/in_stall with red/green/blue/alpha_bits, one
// pixel of the region per transfer, in raster order.
// Output channel: out_valid/out_stall with element_index, four slots,
// channel_count, wide_elements, out_of_range and frame_last.
// Config channel: cfg_valid/cfg_ready, cfg_index selects register 0..7,
// cfg_data carries the value; write only while the block is idle.
// Each pixel passes the input register, then the result register. Throughput:
// one pixel per clock while the receiver does not stall, set by the single
// conversion and index pass between the two registers.
// Reset clears the registers to their defaults and the column/row counters
// to zero; both pipeline stages come up empty.
// When the receiver stalls, the result register holds and the input stage
// keeps one pixel; in_stall rises only when both stages are full.
module float_pixel_pack_rotate_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] red_bits,
  input  logic [31:0] green_bits,
  input  logic [31:0] blue_bits,
  input  logic [31:0] alpha_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [fpprot_pkg::IdxW-1:0] element_index,
  output logic [15:0] slot_zero,
  output logic [15:0] slot_one,
  output logic [15:0] slot_two,
  output logic [15:0] slot_three,
  output logic [2:0]  channel_count,
  output logic        wide_elements,
  output logic        out_of_range,
  output logic        frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fpprot_pkg::*;

  cfg_t cfg;
  logic [CntW-1:0] column_count, row_count;
  logic s1_valid;
  logic [31:0] s1_ch [4];
  pos_t s1_pos;
  logic in_take, s1_move, out_free;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign s1_move = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{rotation: '0, format: '0, region_w: DimW'(1), region_h: DimW'(1),
               target_w: DimW'(1), target_h: DimW'(1), offset_x: '0, offset_y: '0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgRotation: cfg.rotation <= cfg_data[1:0];
        CfgFormat:   cfg.format <= cfg_data[2:0];
        CfgRegionW:  cfg.region_w <= cfg_data[DimW-1:0];
        CfgRegionH:  cfg.region_h <= cfg_data[DimW-1:0];
        CfgTargetW:  cfg.target_w <= cfg_data[DimW-1:0];
        CfgTargetH:  cfg.target_h <= cfg_data[DimW-1:0];
        CfgOffsetX:  cfg.offset_x <= cfg_data[CntW-1:0];
        CfgOffsetY:  cfg.offset_y <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Raster counters advance at the input transfer.
  logic [DimW-1:0] ew, eh;
  logic row_end, last;
  always_comb begin
    ew = eff_size(cfg.region_w);
    eh = eff_size(cfg.region_h);
    row_end = ({1'b0, column_count} + DimW'(1)) >= ew;
    last = row_end && (({1'b0, row_count} + DimW'(1)) >= eh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_take) begin
        if (row_end) begin
          column_count <= '0;
          row_count <= last ? '0 : row_count + CntW'(1);
        end else begin
          column_count <= column_count + CntW'(1);
        end
      end
      if (in_take) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch[0] <= red_bits;
      s1_ch[1] <= green_bits;
      s1_ch[2] <= blue_bits;
      s1_ch[3] <= alpha_bits;
      s1_pos <= '{col: column_count, row: row_count, last: last};
    end
  end

  logic wide, swap, three;
  logic [2:0] step;
  logic [15:0] v [4];
  logic [IdxW-1:0] idx;
  logic outside;

  always_comb begin
    wide = 1'b0;
    swap = 1'b0;
    three = 1'b0;
    unique case (cfg.format)
      FmtBgra8:  swap = 1'b1;
      FmtRgba16: wide = 1'b1;
      FmtRgb16: begin
        wide = 1'b1;
        three = 1'b1;
      end
      FmtRgb8:   three = 1'b1;
      default: ;
    endcase
    step = three ? 3'd3 : 3'd4;
  end

  for (genvar g = 0; g < 4; g++) begin : g_conv
    fpprot_conv u_conv (.bits_in(s1_ch[g]), .wide(wide), .value(v[g]));
  end

  fpprot_place u_place (
    .cfg(cfg), .pos(s1_pos), .step(step), .index(idx), .outside(outside)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      element_index <= idx;
      slot_zero <= swap ? v[2] : v[0];
      slot_one <= v[1];
      slot_two <= swap ? v[0] : v[2];
      slot_three <= three ? 16'h0 : v[3];
      channel_count <= step;
      wide_elements <= wide;
      out_of_range <= outside;
      frame_last <= s1_pos.last;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(element_index))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("stall without full pipe");
  a_range_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> element_index == '0)
    else $error("index set for outside pixel");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> channel_count == 3'd3 || channel_count == 3'd4)
    else $error("bad channel count");

endmodule

// ===== dv/float_pixel_pack_rotate_top_tb.sv =====
module float_pixel_pack_rotate_top_tb;
  import fpprot_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [15:0]     s0;
    logic [15:0]     s1;
    logic [15:0]     s2;
    logic [15:0]     s3;
    logic [2:0]      count;
    logic            wide;
    logic            oor;
    logic            last;
  } pixel_out_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] red_bits;
  logic [31:0] green_bits;
  logic [31:0] blue_bits;
  logic [31:0] alpha_bits;
  logic        out_valid;
  logic        out_stall;
  logic [IdxW-1:0] element_index;
  logic [15:0] slot_zero;
  logic [15:0] slot_one;
  logic [15:0] slot_two;
  logic [15:0] slot_three;
  logic [2:0]  channel_count;
  logic        wide_elements;
  logic        out_of_range;
  logic        frame_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  float_pixel_pack_rotate_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .red_bits(red_bits), .green_bits(green_bits),
    .blue_bits(blue_bits), .alpha_bits(alpha_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .element_index(element_index),
    .slot_zero(slot_zero), .slot_one(slot_one),
    .slot_two(slot_two), .slot_three(slot_three),
    .channel_count(channel_count), .wide_elements(wide_elements),
    .out_of_range(out_of_range), .frame_last(frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the raster counters
  logic [1:0]      rot_q;
  logic [2:0]      fmt_q;
  logic [DimW-1:0] reg_w_q, reg_h_q, tgt_w_q, tgt_h_q;
  logic [CntW-1:0] off_x_q, off_y_q;
  int unsigned     col_q, row_q;

  pixel_out_t pending_pixels[$];
  int         mismatches;
  int         hold_left;
  int         sent_pixels;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Channel scale by 65535 with single-precision rounding, then truncate and clamp
  function automatic logic [15:0] to_unorm16(input logic [31:0] b);
    logic [7:0]       ex;
    logic [22:0]      fr;
    logic [63:0]      prod, q, rem, half, val;
    int               e, s, len;
    ex = b[30:23];
    fr = b[22:0];
    if (b[31]) return 16'd0;
    if (ex == 8'hFF) return (fr != 0) ? 16'd0 : ChannelMax;
    if (ex == 8'd0 && fr == 23'd0) return 16'd0;
    if (ex == 8'd0) begin
      prod = {41'd0, fr};
      e = -149;
    end else begin
      prod = {40'd0, 1'b1, fr};
      e = int'(ex) - 150;
    end
    prod = prod * 64'd65535;
    len = 0;
    for (int i = 0; i < 64; i++) if (prod[i]) len = i + 1;
    q = prod;
    if (len > 24) begin
      s = len - 24;
      half = 64'd1 << (s - 1);
      rem = prod & ((64'd1 << s) - 64'd1);
      q = prod >> s;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      e = e + s;
    end
    if (e >= 24) return ChannelMax;
    if (e >= 0) val = q << e;
    else if (e <= -63) val = 64'd0;
    else val = q >> (-e);
    if (val >= 64'd65535) return ChannelMax;
    return val[15:0];
  endfunction

  function automatic int unsigned clamp_dim(input logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDimension) return MaxDimension;
    return v;
  endfunction

  function automatic pixel_out_t place_pixel(input logic [31:0] r, input logic [31:0] g,
                                             input logic [31:0] bl, input logic [31:0] a);
    pixel_out_t  p;
    logic [15:0] v[4];
    logic [15:0] sl[4];
    int          step;
    logic        wide, swap;
    longint      x, y, px, py, tw, th, ox, oy;
    longint      idx;
    logic        row_end;
    step = 4;
    wide = 1'b0;
    swap = 1'b0;
    case (fmt_q)
      FmtBgra8:  swap = 1'b1;
      FmtRgba16: wide = 1'b1;
      FmtRgb16: begin
        wide = 1'b1;
        step = 3;
      end
      FmtRgb8:   step = 3;
      default: ;
    endcase
    v[0] = to_unorm16(r);
    v[1] = to_unorm16(g);
    v[2] = to_unorm16(bl);
    v[3] = to_unorm16(a);
    for (int c = 0; c < 4; c++) begin
      if (!wide) v[c] = v[c] >> 8;
      sl[c] = 16'd0;
    end
    for (int c = 0; c < step; c++) begin
      if (swap && (c == 0 || c == 2)) sl[2 - c] = v[c];
      else sl[c] = v[c];
    end
    x = col_q;
    y = row_q;
    px = off_x_q;
    py = off_y_q;
    tw = tgt_w_q;
    th = tgt_h_q;
    case (rot_q)
      Rot90: begin
        oy = x + py;
        ox = tw - (y + px) - 1;
      end
      Rot180: begin
        oy = th - (y + py) - 1;
        ox = tw - (x + px) - 1;
      end
      Rot270: begin
        oy = th - (x + py) - 1;
        ox = y + px;
      end
      default: begin
        oy = y + py;
        ox = x + px;
      end
    endcase
    p.oor = (ox < 0) || (ox >= tw) || (oy < 0) || (oy >= th);
    idx = p.oor ? 64'sd0 : ((oy * tw) + ox) * step;
    row_end = (col_q + 1) >= clamp_dim(reg_w_q);
    p.last = row_end && ((row_q + 1) >= clamp_dim(reg_h_q));
    if (row_end) begin
      col_q = 0;
      row_q = p.last ? 0 : row_q + 1;
    end else begin
      col_q = col_q + 1;
    end
    p.index = idx[IdxW-1:0];
    p.s0 = sl[0];
    p.s1 = sl[1];
    p.s2 = sl[2];
    p.s3 = sl[3];
    p.count = 3'(step);
    p.wide = wide;
    return p;
  endfunction

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    pixel_out_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{element_index, slot_zero, slot_one, slot_two, slot_three,
              channel_count, wide_elements, out_of_range, frame_last};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: idx %h/%h slots %h %h %h %h / %h %h %h %h cnt %0d/%0d",
                     got.index, want.index, got.s0, got.s1, got.s2, got.s3,
                     want.s0, want.s1, want.s2, want.s3, got.count, want.count,
                     " wide %b/%b oor %b/%b last %b/%b", got.wide, want.wide,
                     got.oor, want.oor, got.last, want.last);
        end
      end
    end
  end

  // Receiver: random stall runs, quiet stretches, and a long hold-off on request
  initial begin
    int run;
    int quiet;
    run = 0;
    quiet = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (run > 0) begin
        run--;
      end else if (quiet > 0) begin
        out_stall <= 1'b0;
        quiet--;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            out_stall <= 1'b1;
            run = $urandom_range(15, 60);
          end
          1: begin
            out_stall <= 1'b0;
            quiet = $urandom_range(50, 150);
          end
          2, 3, 4, 5: begin
            out_stall <= 1'b1;
            run = $urandom_range(0, 3);
          end
          default: begin
            out_stall <= 1'b0;
            run = $urandom_range(0, 4);
          end
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pixel(input logic [31:0] r, input logic [31:0] g,
                            input logic [31:0] bl, input logic [31:0] a, input int gap);
    in_valid <= 1'b1;
    red_bits <= r;
    green_bits <= g;
    blue_bits <= bl;
    alpha_bits <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(place_pixel(r, g, bl, a));
    sent_pixels++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Leave cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CfgRotation: rot_q = val[1:0];
      CfgFormat:   fmt_q = val[2:0];
      CfgRegionW:  reg_w_q = val[DimW-1:0];
      CfgRegionH:  reg_h_q = val[DimW-1:0];
      CfgTargetW:  tgt_w_q = val[DimW-1:0];
      CfgTargetH:  tgt_h_q = val[DimW-1:0];
      CfgOffsetX:  off_x_q = val[CntW-1:0];
      default:     off_y_q = val[CntW-1:0];
    endcase
  endtask

  task automatic set_layout(input logic [1:0] rot, input logic [2:0] fmt,
                            input int rw, input int rh, input int tw, input int th,
                            input int ox, input int oy);
    wait_drained();
    write_reg(CfgRotation, rot);
    write_reg(CfgFormat, fmt);
    write_reg(CfgRegionW, rw);
    write_reg(CfgRegionH, rh);
    write_reg(CfgTargetW, tw);
    write_reg(CfgTargetH, th);
    write_reg(CfgOffsetX, ox);
    write_reg(CfgOffsetY, oy);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_channel();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
      5: return 32'h3F800000;
      6: return {1'b0, 8'($urandom_range(127, 142)), 23'($urandom)};
      7: begin
        case ($urandom_range(0, 5))
          0: return 32'h00000000;
          1: return 32'h80000000;
          2: return 32'h7F800000;
          3: return 32'h7FC00000 | 32'($urandom_range(0, 1023));
          4: return 32'h3F7FFFFF - 32'($urandom_range(0, 300));
          default: return 32'h37800000 + 32'($urandom_range(0, 255));
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_channel_extremes();
    logic [31:0] specials[12];
    specials = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                 32'h3F800000, 32'hBF800000, 32'h00000001, 32'h7F7FFFFF, 32'h3F7FFFFF,
                 32'h37800080, 32'hFFFFFFFF};
    set_layout(Rot0, FmtRgba16, 4, 3, 4, 3, 0, 0);
    for (int i = 0; i < 12; i++)
      send_pixel(specials[i], specials[(i + 3) % 12], specials[(i + 7) % 12],
                 specials[11 - i], 0);
  endtask

  task automatic test_formats_rotations();
    for (int f = 0; f < 8; f++) begin
      set_layout(2'(f % 4), 3'(f), 2, 1, 3, 3, f % 2, 0);
      send_pixel(32'h3F000000, 32'h3E800000, 32'h3F400000, 32'h3F800000, 1);
      send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), 0);
    end
    // Widest targets and offsets with zero regions, then empty target and oversized regions
    set_layout(Rot180, FmtRgba8, 0, 0, 8192, 8192, 8191, 8191);
    send_pixel(32'h3F800000, 32'h0, 32'h3F000000, 32'h7F800000, 0);
    set_layout(Rot90, FmtRgb16, 16383, 2, 0, 0, 0, 0);
    send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), 0);
    set_layout(Rot270, FmtRgb8, 3, 8192, 8192, 8192, 0, 0);
    send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), 0);
  endtask

  task automatic test_backpressure();
    set_layout(Rot90, FmtBgra8, 5, 4, 8, 8, 1, 2);
    wait_drained();
    hold_left = 300;
    for (int i = 0; i < 40; i++)
      send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), 0);
    wait_drained();
    for (int i = 0; i < 10; i++)
      send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), pick_gap());
  endtask

  task automatic test_random_regions();
    int n;
    int tw, th;
    while (sent_pixels < 1650) begin
      tw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8192) : $urandom_range(1, 20);
      th = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8192) : $urandom_range(1, 20);
      set_layout(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                 $urandom_range(0, 12), $urandom_range(0, 10), tw, th,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 6),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 6));
      n = $urandom_range(10, 90);
      for (int i = 0; i < n; i++)
        send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), pick_gap());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    red_bits = '0;
    green_bits = '0;
    blue_bits = '0;
    alpha_bits = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgRotation;
    cfg_data = '0;
    hold_left = 0;
    mismatches = 0;
    sent_pixels = 0;
    rot_q = Rot0;
    fmt_q = FmtRgba8;
    reg_w_q = 1;
    reg_h_q = 1;
    tgt_w_q = 1;
    tgt_h_q = 1;
    off_x_q = 0;
    off_y_q = 0;
    col_q = 0;
    row_q = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Default registers first
    send_pixel(32'h3F800000, 32'h3F000000, 32'h0, 32'h7F800000, 2);
    test_channel_extremes();
    test_formats_rotations();
    test_backpressure();
    test_random_regions();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
